[src/assert_macros.svh]
// Concurrent assertion helpers; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define RC4_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define RC4_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define RC4_ASSERT_IMPL(label, clk, rstn, ante, cons)

`define RC4_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

[src/rc4_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rc4_pkg;

    localparam int TABLE_SIZE = 256;

    localparam logic [1:0] ACT_LOAD     = 2'd0;
    localparam logic [1:0] ACT_SCHEDULE = 2'd1;
    localparam logic [1:0] ACT_CRYPT    = 2'd2;

    localparam logic REG_KEY_LENGTH = 1'b0;
    localparam logic [8:0] KEY_LENGTH_RESET = 9'd16;

    typedef logic [3:0] step_t;

    localparam step_t P_IDLE = 4'd0;
    localparam step_t P_LOAD = 4'd1;
    localparam step_t P_FILL = 4'd2;
    localparam step_t P_KA   = 4'd3;
    localparam step_t P_KB   = 4'd4;
    localparam step_t P_KC   = 4'd5;
    localparam step_t P_KD   = 4'd6;
    localparam step_t P_KE   = 4'd7;
    localparam step_t P_C0   = 4'd8;
    localparam step_t P_C1   = 4'd9;
    localparam step_t P_C2   = 4'd10;
    localparam step_t P_C3   = 4'd11;
    localparam step_t P_C4   = 4'd12;
    localparam step_t P_C5   = 4'd13;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] key_index;
        logic [7:0] key_byte;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [7:0] keystream_byte;
    } out_item_t;

    typedef enum logic [2:0] {
        ADDR_N       = 3'd0,
        ADDR_ACC     = 3'd1,
        ADDR_ACC_SUM = 3'd2,
        ADDR_I       = 3'd3,
        ADDR_I_INC   = 3'd4,
        ADDR_J       = 3'd5,
        ADDR_J_SUM   = 3'd6,
        ADDR_T       = 3'd7
    } addr_sel_t;

    typedef enum logic [1:0] {
        WD_N     = 2'd0,
        WD_RDATA = 2'd1,
        WD_A     = 2'd2
    } wd_sel_t;

    typedef enum logic [2:0] {
        JC_NEXT = 3'd0,
        JC_JUMP = 3'd1,
        JC_FILL = 3'd2,
        JC_LOOP = 3'd3,
        JC_OUT  = 3'd4
    } jc_t;

    typedef struct packed {
        addr_sel_t addr_sel;
        wd_sel_t   wd_sel;
        logic      perm_we;
        logic      key_we;
        logic      n_inc;
        logic      kpos_inc;
        logic      ka_clr;
        logic      acc_ld;
        logic      a_ld;
        logic      b_ld;
        logic      i_inc;
        logic      j_ld;
        logic      ij_clr;
        logic      out_ld;
        jc_t       jc;
        step_t     target;
    } ctrl_t;

    typedef struct packed {
        logic n_last;
    } stat_t;

    function automatic ctrl_t ucode_word(input step_t pc);
        ctrl_t cw;
        cw = ctrl_t'('0);
        cw.addr_sel = ADDR_N;
        cw.wd_sel   = WD_N;
        cw.jc       = JC_NEXT;
        cw.target   = P_IDLE;
        unique case (pc)
            P_IDLE: begin
                cw.jc = JC_JUMP;
            end
            P_LOAD: begin
                cw.key_we = 1'b1;
                cw.jc     = JC_JUMP;
            end
            P_FILL: begin
                cw.perm_we = 1'b1;
                cw.n_inc   = 1'b1;
                cw.ka_clr  = 1'b1;
                cw.jc      = JC_FILL;
                cw.target  = P_FILL;
            end
            P_KA: begin
                cw.addr_sel = ADDR_N;
            end
            P_KB: begin
                cw.addr_sel = ADDR_ACC_SUM;
                cw.acc_ld   = 1'b1;
                cw.a_ld     = 1'b1;
            end
            P_KC: begin
                cw.addr_sel = ADDR_N;
                cw.wd_sel   = WD_RDATA;
                cw.perm_we  = 1'b1;
            end
            P_KD: begin
                cw.addr_sel = ADDR_ACC;
                cw.wd_sel   = WD_A;
                cw.perm_we  = 1'b1;
                cw.n_inc    = 1'b1;
                cw.kpos_inc = 1'b1;
                cw.jc       = JC_LOOP;
                cw.target   = P_KA;
            end
            P_KE: begin
                cw.ij_clr = 1'b1;
                cw.jc     = JC_JUMP;
            end
            P_C0: begin
                cw.addr_sel = ADDR_I_INC;
                cw.i_inc    = 1'b1;
            end
            P_C1: begin
                cw.addr_sel = ADDR_J_SUM;
                cw.a_ld     = 1'b1;
                cw.j_ld     = 1'b1;
            end
            P_C2: begin
                cw.addr_sel = ADDR_I;
                cw.wd_sel   = WD_RDATA;
                cw.perm_we  = 1'b1;
                cw.b_ld     = 1'b1;
            end
            P_C3: begin
                cw.addr_sel = ADDR_J;
                cw.wd_sel   = WD_A;
                cw.perm_we  = 1'b1;
            end
            P_C4: begin
                cw.addr_sel = ADDR_T;
            end
            P_C5: begin
                cw.addr_sel = ADDR_T;
                cw.out_ld   = 1'b1;
                cw.jc       = JC_OUT;
            end
            default: begin
                cw.jc = JC_JUMP;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

[src/rc4_stream_cipher.sv]
`timescale 1ns / 1ps
`default_nettype none

// RC4 engine driven by a small microcode sequencer over one single-port-style
// 256-byte permutation RAM and a 256-byte key RAM. A load transaction writes
// its key byte to the key RAM; a crypt transaction is an accept plus six steps
// of permutation RAM access (read S[i], read S[j], two swap writes, read S[t],
// result); a schedule transaction is an identity fill of the permutation, then
// four RAM steps per entry over 256 entries. After reset the block runs an
// identity fill of the permutation before s_ready first goes high;
// key_length can be written over APB meanwhile. The result register lets a
// finished byte wait on m_ready while the next transaction is accepted.
// Key bytes must be loaded before a schedule reads them.

`include "assert_macros.svh"

module rc4_stream_cipher (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  rc4_pkg::in_item_t       s_data,
    output logic                    m_valid,
    input  wire                     m_ready,
    output rc4_pkg::out_item_t      m_data,
    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire  [2:0]              paddr,
    input  wire  [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic               accept;
    logic               out_full;
    logic               out_load;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [8:0]         key_length_reg;
    rc4_pkg::ctrl_t     ctrl;
    rc4_pkg::stat_t     stat;
    rc4_pkg::out_item_t result;
    rc4_pkg::out_item_t out_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == rc4_pkg::REG_KEY_LENGTH) ? {23'd0, key_length_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_length_reg <= rc4_pkg::KEY_LENGTH_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == rc4_pkg::REG_KEY_LENGTH) begin
            key_length_reg <= pwdata[8:0];
        end
    end

    assign accept   = s_valid && s_ready;
    assign out_full = out_valid_reg && !m_ready;
    assign out_load = ctrl.out_ld && !out_full;

    rc4_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .action  (s_data.action),
        .out_full(out_full),
        .stat    (stat),
        .in_ready(s_ready),
        .ctrl    (ctrl)
    );

    rc4_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .in_item   (s_data),
        .key_length(key_length_reg),
        .ctrl      (ctrl),
        .stat      (stat),
        .result    (result)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    `RC4_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn,
        accept && (s_data.action == rc4_pkg::ACT_LOAD
            || s_data.action == rc4_pkg::ACT_SCHEDULE
            || s_data.action == rc4_pkg::ACT_CRYPT),
        !s_ready)
    `RC4_ASSERT_IMPL(a_result_from_busy, aclk, aresetn, $rose(m_valid), $past(!s_ready))

endmodule

`default_nettype wire

[src/rc4_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[src/rc4_seq.sv]
`timescale 1ns / 1ps
`default_nettype none

module rc4_seq (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  accept,
    input  wire  [1:0]           action,
    input  wire                  out_full,
    input  rc4_pkg::stat_t       stat,
    output logic                 in_ready,
    output rc4_pkg::ctrl_t       ctrl
);

    rc4_pkg::step_t pc_reg;
    rc4_pkg::step_t pc_next;
    logic           sched_reg;
    logic           sched_next;

    assign ctrl     = rc4_pkg::ucode_word(pc_reg);
    assign in_ready = (pc_reg == rc4_pkg::P_IDLE);

    always_comb begin
        pc_next = pc_reg;
        if (pc_reg == rc4_pkg::P_IDLE) begin
            if (accept) begin
                unique case (action)
                    rc4_pkg::ACT_LOAD:     pc_next = rc4_pkg::P_LOAD;
                    rc4_pkg::ACT_SCHEDULE: pc_next = rc4_pkg::P_FILL;
                    rc4_pkg::ACT_CRYPT:    pc_next = rc4_pkg::P_C0;
                    default:               pc_next = rc4_pkg::P_IDLE;
                endcase
            end
        end else begin
            unique case (ctrl.jc)
                rc4_pkg::JC_NEXT: pc_next = pc_reg + 4'd1;
                rc4_pkg::JC_JUMP: pc_next = ctrl.target;
                rc4_pkg::JC_FILL: begin
                    if (!stat.n_last) begin
                        pc_next = ctrl.target;
                    end else if (sched_reg) begin
                        pc_next = pc_reg + 4'd1;
                    end else begin
                        pc_next = rc4_pkg::P_IDLE;
                    end
                end
                rc4_pkg::JC_LOOP: pc_next = stat.n_last ? pc_reg + 4'd1 : ctrl.target;
                rc4_pkg::JC_OUT:  pc_next = out_full ? pc_reg : ctrl.target;
                default:          pc_next = rc4_pkg::P_IDLE;
            endcase
        end
    end

    always_comb begin
        sched_next = sched_reg;
        if (accept && action == rc4_pkg::ACT_SCHEDULE) begin
            sched_next = 1'b1;
        end else if (ctrl.ij_clr) begin
            sched_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg    <= rc4_pkg::P_FILL;
            sched_reg <= 1'b0;
        end else begin
            pc_reg    <= pc_next;
            sched_reg <= sched_next;
        end
    end

endmodule

`default_nettype wire

[src/rc4_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module rc4_datapath (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  accept,
    input  rc4_pkg::in_item_t    in_item,
    input  wire  [8:0]           key_length,
    input  rc4_pkg::ctrl_t       ctrl,
    output rc4_pkg::stat_t       stat,
    output rc4_pkg::out_item_t   result
);

    rc4_pkg::in_item_t item_reg;
    logic [7:0] n_reg;
    logic [7:0] kpos_reg;
    logic [7:0] acc_reg;
    logic [7:0] a_reg;
    logic [7:0] b_reg;
    logic [7:0] i_reg;
    logic [7:0] j_reg;

    logic [7:0] perm_rdata;
    logic [7:0] key_rdata;
    logic [7:0] perm_addr;
    logic [7:0] perm_wdata;
    logic [7:0] acc_sum;
    logic [7:0] i_inc;
    logic [7:0] j_sum;
    logic [7:0] t_idx;
    logic [8:0] eff_len;
    logic       kpos_wrap;

    assign acc_sum = acc_reg + perm_rdata + key_rdata;
    assign i_inc   = i_reg + 8'd1;
    assign j_sum   = j_reg + perm_rdata;
    assign t_idx   = a_reg + b_reg;

    always_comb begin
        if (key_length == 9'd0) begin
            eff_len = 9'd1;
        end else if (key_length > 9'(rc4_pkg::TABLE_SIZE)) begin
            eff_len = 9'(rc4_pkg::TABLE_SIZE);
        end else begin
            eff_len = key_length;
        end
    end

    assign kpos_wrap   = ({1'b0, kpos_reg} + 9'd1) == eff_len;
    assign stat.n_last = (n_reg == 8'hFF);

    always_comb begin
        unique case (ctrl.addr_sel)
            rc4_pkg::ADDR_N:       perm_addr = n_reg;
            rc4_pkg::ADDR_ACC:     perm_addr = acc_reg;
            rc4_pkg::ADDR_ACC_SUM: perm_addr = acc_sum;
            rc4_pkg::ADDR_I:       perm_addr = i_reg;
            rc4_pkg::ADDR_I_INC:   perm_addr = i_inc;
            rc4_pkg::ADDR_J:       perm_addr = j_reg;
            rc4_pkg::ADDR_J_SUM:   perm_addr = j_sum;
            rc4_pkg::ADDR_T:       perm_addr = t_idx;
            default:               perm_addr = n_reg;
        endcase
    end

    always_comb begin
        unique case (ctrl.wd_sel)
            rc4_pkg::WD_N:     perm_wdata = n_reg;
            rc4_pkg::WD_RDATA: perm_wdata = perm_rdata;
            rc4_pkg::WD_A:     perm_wdata = a_reg;
            default:           perm_wdata = n_reg;
        endcase
    end

    rc4_ram #(
        .WIDTH(8),
        .DEPTH(rc4_pkg::TABLE_SIZE)
    ) u_perm_ram (
        .clk  (aclk),
        .we   (ctrl.perm_we),
        .waddr(perm_addr),
        .wdata(perm_wdata),
        .raddr(perm_addr),
        .rdata(perm_rdata)
    );

    rc4_ram #(
        .WIDTH(8),
        .DEPTH(rc4_pkg::TABLE_SIZE)
    ) u_key_ram (
        .clk  (aclk),
        .we   (ctrl.key_we),
        .waddr(item_reg.key_index),
        .wdata(item_reg.key_byte),
        .raddr(kpos_reg),
        .rdata(key_rdata)
    );

    assign result.out_byte       = item_reg.data_byte ^ perm_rdata;
    assign result.keystream_byte = perm_rdata;

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= in_item;
        end
        if (ctrl.a_ld) begin
            a_reg <= perm_rdata;
        end
        if (ctrl.b_ld) begin
            b_reg <= perm_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg    <= 8'd0;
            kpos_reg <= 8'd0;
            acc_reg  <= 8'd0;
            i_reg    <= 8'd0;
            j_reg    <= 8'd0;
        end else begin
            if (ctrl.n_inc) begin
                n_reg <= n_reg + 8'd1;
            end
            if (ctrl.ka_clr) begin
                kpos_reg <= 8'd0;
                acc_reg  <= 8'd0;
            end else begin
                if (ctrl.kpos_inc) begin
                    kpos_reg <= kpos_wrap ? 8'd0 : kpos_reg + 8'd1;
                end
                if (ctrl.acc_ld) begin
                    acc_reg <= acc_sum;
                end
            end
            if (ctrl.ij_clr) begin
                i_reg <= 8'd0;
                j_reg <= 8'd0;
            end else begin
                if (ctrl.i_inc) begin
                    i_reg <= i_inc;
                end
                if (ctrl.j_ld) begin
                    j_reg <= j_sum;
                end
            end
        end
    end

endmodule

`default_nettype wire
